// File: hdl/int3_key_value_table_assert.svh
// ============================================================================
// int3_key_value_table_assert.svh
// Assertion macros used by the key-value table CAM.
// ============================================================================
`ifndef INT3_KEY_VALUE_TABLE_ASSERT_SVH
`define INT3_KEY_VALUE_TABLE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define IKVT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define IKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never hold.
`define IKVT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: hdl/ikvt_pkg.sv
// ============================================================================
// ikvt_pkg
// Types, sizes and codes shared by the key-value table modules.
// ============================================================================
`default_nettype none

package ikvt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int COORD_W     = 32;
  localparam int KEY_W       = 3 * COORD_W;
  localparam int DATA_W      = 32;

  // Priority pick is done in groups of cells.
  localparam int GRP_SIZE    = 8;
  localparam int GRP_W       = $clog2(GRP_SIZE);
  localparam int NUM_GRP     = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_DEPTH   = NUM_GRP * GRP_SIZE;
  localparam int PAD_W       = $clog2(NUM_GRP) + GRP_W;

  // Request codes.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Status codes.
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_PRESENT = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;
  localparam logic [1:0] STS_MISSING = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_GROUP,
    ST_PICK,
    ST_ACT,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic act;
    logic rsp_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

  // Cell update commands into the CAM.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
  } cam_wr_t;

  // Result of the match and free-cell pick.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } cam_pick_t;

endpackage

`default_nettype wire

// File: hdl/ikvt_req_if.sv
// ============================================================================
// ikvt_req_if
// Request channel: valid/ready handshake with the request payload.
// ============================================================================
`default_nettype none

interface ikvt_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         req_type;
  logic signed [ikvt_pkg::COORD_W-1:0] key_x;
  logic signed [ikvt_pkg::COORD_W-1:0] key_y;
  logic signed [ikvt_pkg::COORD_W-1:0] key_z;
  logic [ikvt_pkg::DATA_W-1:0]        entry_value;

  modport source (output valid, req_type, key_x, key_y, key_z, entry_value,
                  input ready);
  modport sink   (input valid, req_type, key_x, key_y, key_z, entry_value,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/ikvt_rsp_if.sv
// ============================================================================
// ikvt_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ============================================================================
`default_nettype none

interface ikvt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [ikvt_pkg::DATA_W-1:0] found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

`default_nettype wire

// File: hdl/ikvt_ram.sv
// ============================================================================
// ikvt_ram
// Generic single-port RAM with registered read data.
// ============================================================================
`default_nettype none

module ikvt_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access a cycle: write, and read the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: hdl/ikvt_cam.sv
// ============================================================================
// ikvt_cam
// Key cells with per-cell compare and a registered two-level priority pick.
// ============================================================================
`default_nettype none

`include "int3_key_value_table_assert.svh"

module ikvt_cam (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ikvt_pkg::KEY_W-1:0]   req_key,
  input  ikvt_pkg::cam_wr_t            cmd,
  output ikvt_pkg::cam_pick_t          pick
);

  typedef struct packed {
    logic                       any;
    logic [ikvt_pkg::GRP_W-1:0] idx;
  } grp_t;

  logic [ikvt_pkg::TABLE_DEPTH-1:0] valid_r;
  logic [ikvt_pkg::KEY_W-1:0]       key_r [ikvt_pkg::TABLE_DEPTH];
  logic [ikvt_pkg::TABLE_DEPTH-1:0] match_r;
  logic [ikvt_pkg::TABLE_DEPTH-1:0] free_r;
  logic [ikvt_pkg::PAD_DEPTH-1:0]   match_pad;
  logic [ikvt_pkg::PAD_DEPTH-1:0]   free_pad;
  grp_t                             mgrp_r [ikvt_pkg::NUM_GRP];
  grp_t                             fgrp_r [ikvt_pkg::NUM_GRP];
  ikvt_pkg::cam_pick_t              pick_nxt;
  ikvt_pkg::cam_pick_t              pick_r;

  // Lowest set bit of one group.
  function automatic grp_t first_set(input logic [ikvt_pkg::GRP_SIZE-1:0] v);
    grp_t res;
    res = '0;
    for (int j = ikvt_pkg::GRP_SIZE - 1; j >= 0; j--) begin
      if (v[j]) begin
        res.any = 1'b1;
        res.idx = ikvt_pkg::GRP_W'(j);
      end
    end
    return res;
  endfunction

  // Valid marks: set on insert, cleared on remove, all clear after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.wr_en) begin
        valid_r[cmd.wr_idx] <= 1'b1;
      end
      if (cmd.clr_en) begin
        valid_r[cmd.clr_idx] <= 1'b0;
      end
    end
  end

  // Key storage is only read while its valid mark is set.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_r[cmd.wr_idx] <= req_key;
    end
  end

  // Every cell compares its own key against the request.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ikvt_pkg::TABLE_DEPTH; i++) begin
      match_r[i] <= valid_r[i] && (key_r[i] == req_key);
      free_r[i]  <= !valid_r[i];
    end
  end

  // Padding cells never match and are never free.
  assign match_pad = ikvt_pkg::PAD_DEPTH'(match_r);
  assign free_pad  = ikvt_pkg::PAD_DEPTH'(free_r);

  // First level of the pick: lowest set bit in each group.
  always_ff @(posedge clk) begin
    for (int g = 0; g < ikvt_pkg::NUM_GRP; g++) begin
      mgrp_r[g] <= first_set(match_pad[g*ikvt_pkg::GRP_SIZE +: ikvt_pkg::GRP_SIZE]);
      fgrp_r[g] <= first_set(free_pad[g*ikvt_pkg::GRP_SIZE +: ikvt_pkg::GRP_SIZE]);
    end
  end

  // Second level: lowest group that has a set bit.
  always_comb begin
    logic [ikvt_pkg::PAD_W-1:0] msel;
    logic [ikvt_pkg::PAD_W-1:0] fsel;
    msel     = '0;
    fsel     = '0;
    pick_nxt = '0;
    for (int g = ikvt_pkg::NUM_GRP - 1; g >= 0; g--) begin
      if (mgrp_r[g].any) begin
        pick_nxt.hit = 1'b1;
        msel = ikvt_pkg::PAD_W'(g * ikvt_pkg::GRP_SIZE) | ikvt_pkg::PAD_W'(mgrp_r[g].idx);
      end
      if (fgrp_r[g].any) begin
        pick_nxt.free = 1'b1;
        fsel = ikvt_pkg::PAD_W'(g * ikvt_pkg::GRP_SIZE) | ikvt_pkg::PAD_W'(fgrp_r[g].idx);
      end
    end
    pick_nxt.hit_idx  = msel[ikvt_pkg::IDX_W-1:0];
    pick_nxt.free_idx = fsel[ikvt_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    pick_r <= pick_nxt;
  end

  assign pick = pick_r;

  // An insert must land in a free cell, and a remove must hit a valid one.
  `IKVT_ASSERT_IMPL(a_wr_free, clk, rst_n, cmd.wr_en, !valid_r[cmd.wr_idx], "insert into a valid cell")
  `IKVT_ASSERT_IMPL(a_clr_valid, clk, rst_n, cmd.clr_en, valid_r[cmd.clr_idx], "remove of a free cell")
  `IKVT_ASSERT_NEXT(a_wr_sets, clk, rst_n, cmd.wr_en, valid_r[$past(cmd.wr_idx)], "insert lost its mark")
  `IKVT_ASSERT_NEVER(a_wr_clr, clk, rst_n, cmd.wr_en && cmd.clr_en, "insert and remove together")

endmodule

`default_nettype wire

// File: hdl/ikvt_ctrl.sv
// ============================================================================
// ikvt_ctrl
// Request sequencer: steps one request through compare, pick, update and
// result.
// ============================================================================
`default_nettype none

module ikvt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ikvt_pkg::ctrl_sts_t sts,
  output ikvt_pkg::ctrl_cmd_t cmd
);

  ikvt_pkg::state_t state_r;
  ikvt_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ikvt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ikvt_pkg::ST_IDLE: begin
        // No request is taken while reset is held.
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load_req = 1'b1;
          state_nxt    = ikvt_pkg::ST_MATCH;
        end
      end
      ikvt_pkg::ST_MATCH: begin
        state_nxt = ikvt_pkg::ST_GROUP;
      end
      ikvt_pkg::ST_GROUP: begin
        state_nxt = ikvt_pkg::ST_PICK;
      end
      ikvt_pkg::ST_PICK: begin
        state_nxt = ikvt_pkg::ST_ACT;
      end
      ikvt_pkg::ST_ACT: begin
        cmd.act   = 1'b1;
        state_nxt = ikvt_pkg::ST_RESP;
      end
      ikvt_pkg::ST_RESP: begin
        // Hold the result until the output register can take it.
        if (sts.out_free) begin
          cmd.rsp_load = 1'b1;
          state_nxt    = ikvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ikvt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ikvt_datapath.sv
// ============================================================================
// ikvt_datapath
// Request register, key cells, value RAM, status logic and output register.
// ============================================================================
`default_nettype none

module ikvt_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ikvt_pkg::ctrl_cmd_t                 cmd,
  output ikvt_pkg::ctrl_sts_t                 sts,
  input  logic [1:0]                          req_type,
  input  logic signed [ikvt_pkg::COORD_W-1:0] key_x,
  input  logic signed [ikvt_pkg::COORD_W-1:0] key_y,
  input  logic signed [ikvt_pkg::COORD_W-1:0] key_z,
  input  logic [ikvt_pkg::DATA_W-1:0]         entry_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [ikvt_pkg::DATA_W-1:0]         out_found_value
);

  logic [1:0]                  req_type_r;
  logic [ikvt_pkg::KEY_W-1:0]  req_key_r;
  logic [ikvt_pkg::DATA_W-1:0] req_value_r;
  ikvt_pkg::cam_wr_t           cam_cmd;
  ikvt_pkg::cam_pick_t         pick;
  logic                        ram_we;
  logic [ikvt_pkg::IDX_W-1:0]  ram_addr;
  logic [ikvt_pkg::DATA_W-1:0] ram_rdata;
  logic [1:0]                  status_nxt;
  logic [1:0]                  status_r;
  logic                        find_hit_r;
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [ikvt_pkg::DATA_W-1:0] out_value_r;

  // Capture the accepted request; it stays put until the result is out.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r  <= req_type;
      req_key_r   <= {key_x, key_y, key_z};
      req_value_r <= entry_value;
    end
  end

  ikvt_cam u_cam (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_key (req_key_r),
    .cmd     (cam_cmd),
    .pick    (pick)
  );

  // Table update and status decision, applied in the update cycle.
  always_comb begin
    cam_cmd         = '0;
    cam_cmd.wr_idx  = pick.free_idx;
    cam_cmd.clr_idx = pick.hit_idx;
    status_nxt      = ikvt_pkg::STS_DONE;
    unique case (req_type_r)
      ikvt_pkg::REQ_INSERT: begin
        if (pick.hit) begin
          status_nxt = ikvt_pkg::STS_PRESENT;
        end else if (!pick.free) begin
          status_nxt = ikvt_pkg::STS_FULL;
        end else begin
          cam_cmd.wr_en = cmd.act;
        end
      end
      ikvt_pkg::REQ_FIND: begin
        if (!pick.hit) begin
          status_nxt = ikvt_pkg::STS_MISSING;
        end
      end
      ikvt_pkg::REQ_REMOVE: begin
        if (pick.hit) begin
          cam_cmd.clr_en = cmd.act;
        end else begin
          status_nxt = ikvt_pkg::STS_MISSING;
        end
      end
      default: begin
        // The unused request code leaves the table alone.
        status_nxt = ikvt_pkg::STS_DONE;
      end
    endcase
  end

  // The value RAM is written on an insert into a free cell and read at the hit cell otherwise.
  assign ram_we   = cam_cmd.wr_en;
  assign ram_addr = (req_type_r == ikvt_pkg::REQ_INSERT) ? pick.free_idx : pick.hit_idx;

  ikvt_ram #(
    .WIDTH (ikvt_pkg::DATA_W),
    .DEPTH (ikvt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req_value_r),
    .rdata (ram_rdata)
  );

  // Hold the status while the RAM read completes.
  always_ff @(posedge clk) begin
    if (cmd.act) begin
      status_r   <= status_nxt;
      find_hit_r <= (req_type_r == ikvt_pkg::REQ_FIND) && pick.hit;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rsp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      out_status_r <= status_r;
      out_value_r  <= find_hit_r ? ram_rdata : '0;
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;

endmodule

`default_nettype wire

// File: hdl/int3_key_value_table.sv
// ============================================================================
// int3_key_value_table
// Exact-match table from a signed 3D grid position to a 32-bit value.
// ============================================================================
//
//   Channel   Dir   Payload                                      Handshake
//   in_req    in    req_type, key_x, key_y, key_z, entry_value   valid/ready
//   out_rsp   out   status, found_value                          valid/ready
//
// One request is in flight at a time; the next request is accepted only after
// the result of the last one has been loaded into the output register.
// On its way a request passes the registered per-cell compare, the two-level
// priority pick over groups of eight cells, and the value RAM read.
// Reset clears all valid marks at once; requests are taken right after it.
// A stalled result is held in the output register and the request that
// produced it is done, so the next request is accepted meanwhile.
// ============================================================================
`default_nettype none

module int3_key_value_table (
  input  logic      clk,
  input  logic      rst_n,
  ikvt_req_if.sink  in_req,
  ikvt_rsp_if.source out_rsp
);

  ikvt_pkg::ctrl_cmd_t cmd;
  ikvt_pkg::ctrl_sts_t sts;
  logic                in_ready;

  ikvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_req.ready = in_ready;

  ikvt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .req_type        (in_req.req_type),
    .key_x           (in_req.key_x),
    .key_y           (in_req.key_y),
    .key_z           (in_req.key_z),
    .entry_value     (in_req.entry_value),
    .out_ready       (out_rsp.ready),
    .out_valid       (out_rsp.valid),
    .out_status      (out_rsp.status),
    .out_found_value (out_rsp.found_value)
  );

endmodule

`default_nettype wire
